// ----- design/gafio_pkg.sv -----
// Shared constants, types and the arctangent table for the gaze angle block.
// No dependencies.
package gafio_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int SQRT_STEPS       = 25;
    localparam int RAD_W            = 50;
    localparam int REM_W            = 28;
    localparam int ROOT_W           = 25;
    localparam int CW               = 29;
    localparam int AW               = 25;
    localparam int IDX_W            = 5;

    localparam logic signed [AW-1:0] DEG90_Q16 = 25'sd5898240;
    localparam logic signed [15:0]   DEG90_Q8  = 16'sd23040;

    typedef struct packed {
        logic [16:0] ae;
        logic [16:0] av;
        logic        e_neg;
        logic        e_pos;
        logic        v_neg;
        logic        sat;
        logic        root_zero;
    } side_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [AW-1:0] atan_entry(input logic [IDX_W-1:0] i);
        logic [AW-1:0] r;
        begin
            case (i)
                5'd0:    r = 25'd2949120;
                5'd1:    r = 25'd1740967;
                5'd2:    r = 25'd919879;
                5'd3:    r = 25'd466945;
                5'd4:    r = 25'd234379;
                5'd5:    r = 25'd117304;
                5'd6:    r = 25'd58666;
                5'd7:    r = 25'd29335;
                5'd8:    r = 25'd14668;
                5'd9:    r = 25'd7334;
                5'd10:   r = 25'd3667;
                5'd11:   r = 25'd1833;
                5'd12:   r = 25'd917;
                5'd13:   r = 25'd458;
                5'd14:   r = 25'd229;
                5'd15:   r = 25'd115;
                5'd16:   r = 25'd57;
                5'd17:   r = 25'd29;
                5'd18:   r = 25'd14;
                5'd19:   r = 25'd7;
                5'd20:   r = 25'd4;
                5'd21:   r = 25'd2;
                5'd22:   r = 25'd1;
                default: r = 25'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- design/gafio_if.sv -----
// Handshake interfaces for the point word in and the angle word out.
// Depends on nothing.
interface gafio_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_corner_x;
    logic signed [15:0] first_corner_y;
    logic signed [15:0] second_corner_x;
    logic signed [15:0] second_corner_y;
    logic signed [15:0] pupil_x;
    logic signed [15:0] pupil_y;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;

    modport source (output valid, first_corner_x, first_corner_y, second_corner_x,
                    second_corner_y, pupil_x, pupil_y, center_x, center_y,
                    input ready);
    modport sink   (input valid, first_corner_x, first_corner_y, second_corner_x,
                    second_corner_y, pupil_x, pupil_y, center_x, center_y,
                    output ready);
endinterface

interface gafio_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] theta;
    logic signed [15:0] phi;

    modport source (output valid, theta, phi, input ready);
    modport sink   (input valid, theta, phi, output ready);
endinterface

// ----- design/gafio_sqrt_cell.sv -----
// One digit of the pipelined integer square root: two radicand bits per cell.
// Depends on gafio_pkg.
module gafio_sqrt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gafio_pkg::RAD_W-1:0]   in_rad,
    input  logic [gafio_pkg::REM_W-1:0]   in_rem,
    input  logic [gafio_pkg::ROOT_W-1:0]  in_root,
    input  gafio_pkg::side_t              in_side,
    output logic                          out_valid,
    output logic [gafio_pkg::RAD_W-1:0]   out_rad,
    output logic [gafio_pkg::REM_W-1:0]   out_rem,
    output logic [gafio_pkg::ROOT_W-1:0]  out_root,
    output gafio_pkg::side_t              out_side
);
    logic [gafio_pkg::REM_W-1:0]  rem_sh;
    logic [gafio_pkg::REM_W-1:0]  trial;
    logic                         ge;
    logic                         valid_reg;
    logic [gafio_pkg::RAD_W-1:0]  rad_reg,  rad_next;
    logic [gafio_pkg::REM_W-1:0]  rem_reg,  rem_next;
    logic [gafio_pkg::ROOT_W-1:0] root_reg, root_next;
    gafio_pkg::side_t             side_reg;

    always_comb
    begin
        rem_sh    = {in_rem[gafio_pkg::REM_W-3:0], in_rad[gafio_pkg::RAD_W-1 -: 2]};
        trial     = {{(gafio_pkg::REM_W-gafio_pkg::ROOT_W-2){1'b0}}, in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[gafio_pkg::ROOT_W-2:0], ge};
        rad_next  = {in_rad[gafio_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;
endmodule

// ----- design/gafio_cordic_cell.sv -----
// One CORDIC vectoring step for both angle lanes (theta and phi).
// Depends on gafio_pkg.
module gafio_cordic_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [gafio_pkg::IDX_W-1:0]        idx,
    input  logic                               in_valid,
    input  logic signed [gafio_pkg::CW-1:0]    in_xt,
    input  logic signed [gafio_pkg::CW-1:0]    in_yt,
    input  logic signed [gafio_pkg::AW-1:0]    in_at,
    input  logic signed [gafio_pkg::CW-1:0]    in_xp,
    input  logic signed [gafio_pkg::CW-1:0]    in_yp,
    input  logic signed [gafio_pkg::AW-1:0]    in_ap,
    input  gafio_pkg::side_t                   in_side,
    output logic                               out_valid,
    output logic signed [gafio_pkg::CW-1:0]    out_xt,
    output logic signed [gafio_pkg::CW-1:0]    out_yt,
    output logic signed [gafio_pkg::AW-1:0]    out_at,
    output logic signed [gafio_pkg::CW-1:0]    out_xp,
    output logic signed [gafio_pkg::CW-1:0]    out_yp,
    output logic signed [gafio_pkg::AW-1:0]    out_ap,
    output gafio_pkg::side_t                   out_side
);
    logic signed [gafio_pkg::AW-1:0] step;
    logic signed [gafio_pkg::CW-1:0] xst, yst, xsp, ysp;
    logic signed [gafio_pkg::CW-1:0] xt_next, yt_next, xp_next, yp_next;
    logic signed [gafio_pkg::AW-1:0] at_next, ap_next;
    logic                            valid_reg;
    logic signed [gafio_pkg::CW-1:0] xt_reg, yt_reg, xp_reg, yp_reg;
    logic signed [gafio_pkg::AW-1:0] at_reg, ap_reg;
    gafio_pkg::side_t                side_reg;

    always_comb
    begin
        step = $signed(gafio_pkg::atan_entry(idx));
        xst  = in_xt >>> idx;
        yst  = in_yt >>> idx;
        xsp  = in_xp >>> idx;
        ysp  = in_yp >>> idx;
        // rotate toward the x axis; y == 0 takes the negative branch
        if (in_yt > 0)
        begin
            xt_next = in_xt + yst;
            yt_next = in_yt - xst;
            at_next = in_at + step;
        end
        else
        begin
            xt_next = in_xt - yst;
            yt_next = in_yt + xst;
            at_next = in_at - step;
        end
        if (in_yp > 0)
        begin
            xp_next = in_xp + ysp;
            yp_next = in_yp - xsp;
            ap_next = in_ap + step;
        end
        else
        begin
            xp_next = in_xp - ysp;
            yp_next = in_yp + xsp;
            ap_next = in_ap - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xt_reg   <= xt_next;
            yt_reg   <= yt_next;
            at_reg   <= at_next;
            xp_reg   <= xp_next;
            yp_reg   <= yp_next;
            ap_reg   <= ap_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_xt    = xt_reg;
    assign out_yt    = yt_reg;
    assign out_at    = at_reg;
    assign out_xp    = xp_reg;
    assign out_yp    = yp_reg;
    assign out_ap    = ap_reg;
    assign out_side  = side_reg;
endmodule

// ----- design/gaze_angle_from_iris_offset.sv -----
// Top level of the gaze angle block: difference and square stages, square root
// cells, CORDIC cells and the output register. Depends on gafio_pkg and gafio_if.
//
// Takes one point word per cycle while the pipe is not held and returns one angle
// word per point word, in order. Stages: two front stages (differences, then
// squares; the radius test sits in front of the first root cell), one cell per
// root digit (25), one cell per CORDIC step (16), and the output register. The
// whole pipe advances together and holds while the output word waits to be taken.
module gaze_angle_from_iris_offset (
    input  logic        clk,
    input  logic        rst_n,
    gafio_in_if.sink    pixels,
    gafio_out_if.source angles
);
    localparam int NS = gafio_pkg::SQRT_STEPS;
    localparam int NC = gafio_pkg::ANGLE_ITERATIONS;

    logic en;

    logic               v0_reg;
    logic signed [16:0] dx_reg, dy_reg, e_reg, v_reg;

    logic               v1_reg;
    logic [32:0]        dxx_reg, dyy_reg, ee_reg;
    logic [16:0]        ae_reg, av_reg;
    logic               e_neg_reg, e_pos_reg, v_neg_reg;
    logic signed [33:0] dxx_full, dyy_full, ee_full;

    logic [33:0]        dsq;
    logic [34:0]        e4;
    logic [33:0]        diff;
    gafio_pkg::side_t   side2;

    logic                            sq_valid [0:NS];
    logic [gafio_pkg::RAD_W-1:0]     sq_rad   [0:NS];
    logic [gafio_pkg::REM_W-1:0]     sq_rem   [0:NS];
    logic [gafio_pkg::ROOT_W-1:0]    sq_root  [0:NS];
    gafio_pkg::side_t                sq_side  [0:NS];

    logic                            c_valid [0:NC];
    logic signed [gafio_pkg::CW-1:0] c_xt    [0:NC];
    logic signed [gafio_pkg::CW-1:0] c_yt    [0:NC];
    logic signed [gafio_pkg::AW-1:0] c_at    [0:NC];
    logic signed [gafio_pkg::CW-1:0] c_xp    [0:NC];
    logic signed [gafio_pkg::CW-1:0] c_yp    [0:NC];
    logic signed [gafio_pkg::AW-1:0] c_ap    [0:NC];
    gafio_pkg::side_t                c_side  [0:NC];

    gafio_pkg::side_t   fs;
    logic signed [15:0] mag_t, mag_p;
    logic signed [15:0] theta_next, phi_next;
    logic               out_valid_reg;
    logic signed [15:0] theta_reg, phi_reg;

    function automatic logic signed [15:0] round_q8(input logic signed [gafio_pkg::AW-1:0] a);
        logic signed [gafio_pkg::AW-1:0] c;
        logic signed [gafio_pkg::AW-1:0] s;
        begin
            if (a < 0)
                c = '0;
            else if (a > gafio_pkg::DEG90_Q16)
                c = gafio_pkg::DEG90_Q16;
            else
                c = a;
            s = (c + gafio_pkg::AW'(128)) >>> 8;
            return s[15:0];
        end
    endfunction

    assign en           = !out_valid_reg || angles.ready;
    assign pixels.ready = en;

    // stage 0: differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= pixels.valid;
            v1_reg        <= v0_reg;
            out_valid_reg <= c_valid[NC];
        end
    end

    assign dxx_full = dx_reg * dx_reg;
    assign dyy_full = dy_reg * dy_reg;
    assign ee_full  = e_reg * e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= 17'(pixels.first_corner_x) - 17'(pixels.second_corner_x);
            dy_reg    <= 17'(pixels.first_corner_y) - 17'(pixels.second_corner_y);
            e_reg     <= 17'(pixels.pupil_x) - 17'(pixels.center_x);
            v_reg     <= 17'(pixels.pupil_y) - 17'(pixels.center_y);
            // stage 1: squares and magnitudes
            dxx_reg   <= dxx_full[32:0];
            dyy_reg   <= dyy_full[32:0];
            ee_reg    <= ee_full[32:0];
            ae_reg    <= e_reg[16] ? 17'(-e_reg) : e_reg;
            av_reg    <= v_reg[16] ? 17'(-v_reg) : v_reg;
            e_neg_reg <= e_reg < 0;
            e_pos_reg <= e_reg > 0;
            v_neg_reg <= v_reg < 0;
            theta_reg <= theta_next;
            phi_reg   <= phi_next;
        end
    end

    // stage 2 (feeds first root cell): radius test and radicand
    always_comb
    begin
        dsq             = {1'b0, dxx_reg} + {1'b0, dyy_reg};
        e4              = {ee_reg, 2'b00};
        diff            = dsq - e4[33:0];
        side2.ae        = ae_reg;
        side2.av        = av_reg;
        side2.e_neg     = e_neg_reg;
        side2.e_pos     = e_pos_reg;
        side2.v_neg     = v_neg_reg;
        side2.sat       = (e4 >= {1'b0, dsq});
        side2.root_zero = 1'b0;
    end

    assign sq_valid[0] = v1_reg;
    assign sq_rad[0]   = {diff, 16'h0000};
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = side2;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_sqrt
            gafio_sqrt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (sq_valid[gi]),
                .in_rad   (sq_rad[gi]),
                .in_rem   (sq_rem[gi]),
                .in_root  (sq_root[gi]),
                .in_side  (sq_side[gi]),
                .out_valid(sq_valid[gi+1]),
                .out_rad  (sq_rad[gi+1]),
                .out_rem  (sq_rem[gi+1]),
                .out_root (sq_root[gi+1]),
                .out_side (sq_side[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        c_side[0]           = sq_side[NS];
        c_side[0].root_zero = (sq_root[NS] == '0);
    end

    assign c_valid[0] = sq_valid[NS];
    assign c_xt[0]    = gafio_pkg::CW'(sq_root[NS]);
    assign c_yt[0]    = gafio_pkg::CW'({sq_side[NS].ae, 9'h000});
    assign c_at[0]    = '0;
    assign c_xp[0]    = gafio_pkg::CW'({sq_side[NS].ae, 8'h00});
    assign c_yp[0]    = gafio_pkg::CW'({sq_side[NS].av, 8'h00});
    assign c_ap[0]    = '0;

    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cordic
            gafio_cordic_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .idx      (gafio_pkg::IDX_W'(gi)),
                .in_valid (c_valid[gi]),
                .in_xt    (c_xt[gi]),
                .in_yt    (c_yt[gi]),
                .in_at    (c_at[gi]),
                .in_xp    (c_xp[gi]),
                .in_yp    (c_yp[gi]),
                .in_ap    (c_ap[gi]),
                .in_side  (c_side[gi]),
                .out_valid(c_valid[gi+1]),
                .out_xt   (c_xt[gi+1]),
                .out_yt   (c_yt[gi+1]),
                .out_at   (c_at[gi+1]),
                .out_xp   (c_xp[gi+1]),
                .out_yp   (c_yp[gi+1]),
                .out_ap   (c_ap[gi+1]),
                .out_side (c_side[gi+1])
            );
        end
    endgenerate

    // final: special cases, clamp, round, sign
    always_comb
    begin
        fs = c_side[NC];
        if (fs.ae == '0)
            mag_t = '0;
        else if (fs.root_zero)
            mag_t = gafio_pkg::DEG90_Q8;
        else
            mag_t = round_q8(c_at[NC]);

        if (fs.av == '0)
            mag_p = '0;
        else if (fs.ae == '0)
            mag_p = gafio_pkg::DEG90_Q8;
        else
            mag_p = round_q8(c_ap[NC]);

        if (fs.sat)
            theta_next = fs.e_pos ? gafio_pkg::DEG90_Q8 : -gafio_pkg::DEG90_Q8;
        else
            theta_next = fs.e_neg ? -mag_t : mag_t;
        phi_next = fs.v_neg ? -mag_p : mag_p;
    end

    assign angles.valid = out_valid_reg;
    assign angles.theta = theta_reg;
    assign angles.phi   = phi_reg;

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.ready == (!angles.valid || angles.ready))
        else $error("input ready does not follow output stall");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |-> (angles.theta <= gafio_pkg::DEG90_Q8 &&
                          angles.theta >= -gafio_pkg::DEG90_Q8))
        else $error("theta out of range");

    a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |-> (angles.phi <= gafio_pkg::DEG90_Q8 &&
                          angles.phi >= -gafio_pkg::DEG90_Q8))
        else $error("phi out of range");

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && c_valid[NC]) |=> angles.valid)
        else $error("finished word lost at output register");
endmodule
